// ===== rtl/skv_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package skv_pkg;

    localparam int CAPACITY      = 64;
    localparam int KEY_WIDTH     = 32;
    localparam int PAYLOAD_WIDTH = 64;
    localparam int CNT_W         = $clog2(CAPACITY + 1);

    localparam int OP_W     = 2;
    localparam int IN_KEY_W = 32;
    localparam int IN_PAY_W = 64;
    localparam int STAT_W   = 2;
    localparam int OCC_W    = 7;

    localparam logic [OP_W-1:0] OP_SET    = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND   = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd2;

    typedef logic [KEY_WIDTH-1:0]     t_key;
    typedef logic [PAYLOAD_WIDTH-1:0] t_pay;

    typedef struct packed {
        logic [OP_W-1:0]     operation;
        logic [IN_KEY_W-1:0] key;
        logic [IN_PAY_W-1:0] payload;
    } t_in;

    typedef struct packed {
        logic [STAT_W-1:0]   status;
        logic [IN_PAY_W-1:0] value;
        logic [OCC_W-1:0]    occupancy;
    } t_out;

    typedef struct packed {
        logic cmp;
        logic upd;
        logic ins;
        logic del;
    } t_cell_cmd;

endpackage

`default_nettype wire

// ===== rtl/skv_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skv_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  skv_pkg::t_cell_cmd  i_cmd,
    input  wire                 i_occ,
    input  skv_pkg::t_key       i_key,
    input  skv_pkg::t_pay       i_pay,
    input  wire                 i_left_lt,
    input  skv_pkg::t_key       i_left_key,
    input  skv_pkg::t_pay       i_left_pay,
    input  skv_pkg::t_key       i_right_key,
    input  skv_pkg::t_pay       i_right_pay,
    output skv_pkg::t_key       o_key,
    output skv_pkg::t_pay       o_pay,
    output logic                o_lt,
    output logic                o_eq
);
    import skv_pkg::*;

    t_key r_key, n_key;
    t_pay r_pay, n_pay;
    logic r_lt, n_lt;
    logic r_eq, n_eq;

    always_comb begin
        n_key = r_key;
        n_pay = r_pay;
        n_lt  = r_lt;
        n_eq  = r_eq;
        if (i_cmd.cmp) begin
            n_lt = i_occ && (r_key < i_key);
            n_eq = i_occ && (r_key == i_key);
        end else if (i_cmd.upd) begin
            if (r_eq) begin
                n_pay = i_pay;
            end
        end else if (i_cmd.ins) begin
            if (!r_lt) begin
                if (i_left_lt) begin
                    n_key = i_key;
                    n_pay = i_pay;
                end else begin
                    n_key = i_left_key;
                    n_pay = i_left_pay;
                end
            end
        end else if (i_cmd.del) begin
            if (!r_lt) begin
                n_key = i_right_key;
                n_pay = i_right_pay;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_pay <= n_pay;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lt <= 1'b0;
            r_eq <= 1'b0;
        end else begin
            r_lt <= n_lt;
            r_eq <= n_eq;
        end
    end

    assign o_key = r_key;
    assign o_pay = r_pay;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;

endmodule

`default_nettype wire

// ===== rtl/sorted_key_value_table_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// pipeline: an accepted beat registers into s1, then s2, then the output beat
// each operation: a compare pass over the cell row,
//   then a shift or write pass, with the next beat accepted during the second
// reset: clears the entry count, the pipeline and the output beat;
//   stored keys and payloads are not cleared and need no clearing pass

module sorted_key_value_table_top (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_in_valid,
    output logic          o_in_ready,
    input  skv_pkg::t_in  i_in_data,
    output logic          o_out_valid,
    input  wire           i_out_ready,
    output skv_pkg::t_out o_out_data
);
    import skv_pkg::*;

    logic                 r_s1_v;
    logic [OP_W-1:0]      r_s1_op;
    t_key                 r_s1_key;
    t_pay                 r_s1_pay;
    logic                 r_s2_v;
    logic [OP_W-1:0]      r_s2_op;
    t_pay                 r_s2_pay;
    logic [CNT_W-1:0]     r_count, n_count;
    logic                 r_out_v;
    t_out                 r_out, n_out;

    logic                 s2_go;
    logic                 hit;
    logic                 full;
    t_pay                 found;
    t_cell_cmd            cmd;

    logic [CAPACITY-1:0]  w_occ;
    logic [CAPACITY-1:0]  w_lt;
    logic [CAPACITY-1:0]  w_eq;
    t_key                 w_key [CAPACITY];
    t_pay                 w_pay [CAPACITY];

    assign s2_go      = r_s2_v && (!r_out_v || i_out_ready);
    assign o_in_ready = !r_s1_v && (!r_s2_v || s2_go);
    assign hit        = |w_eq;
    assign full       = (r_count == CNT_W'(CAPACITY));

    assign cmd.cmp = r_s1_v;
    assign cmd.upd = s2_go && (r_s2_op == OP_SET) && hit;
    assign cmd.ins = s2_go && (r_s2_op == OP_SET) && !hit && !full;
    assign cmd.del = s2_go && (r_s2_op == OP_REMOVE) && hit;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            t_key left_key, right_key;
            t_pay left_pay, right_pay;
            logic left_lt;

            assign w_occ[gi] = (r_count > CNT_W'(gi));

            if (gi == 0) begin : g_first
                assign left_lt  = 1'b1;
                assign left_key = w_key[gi];
                assign left_pay = w_pay[gi];
            end else begin : g_mid
                assign left_lt  = w_lt[gi-1];
                assign left_key = w_key[gi-1];
                assign left_pay = w_pay[gi-1];
            end

            if (gi == CAPACITY - 1) begin : g_last
                assign right_key = w_key[gi];
                assign right_pay = w_pay[gi];
            end else begin : g_inner
                assign right_key = w_key[gi+1];
                assign right_pay = w_pay[gi+1];
            end

            skv_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_cmd       (cmd),
                .i_occ       (w_occ[gi]),
                .i_key       (r_s1_key),
                .i_pay       (r_s2_pay),
                .i_left_lt   (left_lt),
                .i_left_key  (left_key),
                .i_left_pay  (left_pay),
                .i_right_key (right_key),
                .i_right_pay (right_pay),
                .o_key       (w_key[gi]),
                .o_pay       (w_pay[gi]),
                .o_lt        (w_lt[gi]),
                .o_eq        (w_eq[gi])
            );
        end
    endgenerate

    always_comb begin
        found = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            found = found | ({PAYLOAD_WIDTH{w_eq[i]}} & w_pay[i]);
        end
    end

    always_comb begin
        n_count = r_count;
        unique case (r_s2_op)
            OP_SET: begin
                if (!hit && !full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            OP_REMOVE: begin
                if (hit) begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            OP_FIND: begin
                n_count = r_count;
            end
            OP_CLEAR: begin
                n_count = '0;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_comb begin
        n_out.status    = ST_OK;
        n_out.value     = '0;
        n_out.occupancy = OCC_W'(n_count);
        unique case (r_s2_op)
            OP_SET: begin
                if (!hit && full) begin
                    n_out.status = ST_FULL;
                end
            end
            OP_REMOVE: begin
                if (!hit) begin
                    n_out.status = ST_MISS;
                end
            end
            OP_FIND: begin
                if (hit) begin
                    n_out.value = IN_PAY_W'(found);
                end else begin
                    n_out.status = ST_MISS;
                end
            end
            OP_CLEAR: begin
                n_out.status = ST_OK;
            end
            default: begin
                n_out.status = ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_count <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_s1_v <= (i_in_valid && o_in_ready);
            if (r_s1_v) begin
                r_s2_v <= 1'b1;
            end else if (s2_go) begin
                r_s2_v <= 1'b0;
            end
            if (s2_go) begin
                r_count <= n_count;
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_s1_op  <= i_in_data.operation;
            r_s1_key <= KEY_WIDTH'(i_in_data.key);
            r_s1_pay <= PAYLOAD_WIDTH'(i_in_data.payload);
        end
        if (r_s1_v) begin
            r_s2_op  <= r_s1_op;
            r_s2_pay <= r_s1_pay;
        end
        if (s2_go) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/skv_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module skv_checker (
    input wire           i_clk,
    input wire           i_rst_n,
    input wire           i_in_valid,
    input wire           o_in_ready,
    input skv_pkg::t_in  i_in_data,
    input wire           o_out_valid,
    input wire           i_out_ready,
    input skv_pkg::t_out o_out_data
);
    import skv_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output beat valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled output beat changed");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_in_data))
        else $error("waiting input beat changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat accepted while an operation is in flight");

    a_value_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status != ST_OK |-> o_out_data.value == '0)
        else $error("nonzero value on a miss or full result");

endmodule

bind sorted_key_value_table_top skv_checker u_skv_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

`default_nettype wire
